// ----- sv/irpd_pkg.sv -----
// Package for the pulse-distance IR decoder: interval class word, register
// indexes, reset values and widths. No dependencies.
package irpd_pkg;

  localparam int unsigned TICK_W     = 16;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned BIT_IDX_W  = $clog2(FRAME_BITS);
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned BYTE_W     = 8;

  // Register indexes on the config port
  localparam logic [REG_IDX_W-1:0] REG_START_CENTER  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_CENTER = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_CENTER   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ONE_CENTER    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE     = 3'd4;

  // Reset values of the registers
  localparam logic [TICK_W-1:0] START_CENTER_RST  = 16'd12442;
  localparam logic [TICK_W-1:0] REPEAT_CENTER_RST = 16'd10368;
  localparam logic [TICK_W-1:0] ZERO_CENTER_RST   = 16'd1032;
  localparam logic [TICK_W-1:0] ONE_CENTER_RST    = 16'd2074;
  localparam logic [TICK_W-1:0] TOLERANCE_RST     = 16'd500;

  // Window hits of one interval, passed from front to back
  typedef struct packed {
    logic start_hit;
    logic repeat_hit;
    logic zero_hit;
    logic one_hit;
  } cls_t;

endpackage

// ----- sv/irpd_front.sv -----
// Front end of the IR decoder: holds the timing registers and classifies each
// incoming interval against the four windows. Depends on irpd_pkg.
module irpd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [irpd_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [irpd_pkg::TICK_W-1:0]       cfg_data,
  input  logic [irpd_pkg::TICK_W-1:0]       interval_ticks,
  output irpd_pkg::cls_t                    cls
);

  logic [irpd_pkg::TICK_W-1:0] start_center;
  logic [irpd_pkg::TICK_W-1:0] repeat_center;
  logic [irpd_pkg::TICK_W-1:0] zero_center;
  logic [irpd_pkg::TICK_W-1:0] one_center;
  logic [irpd_pkg::TICK_W-1:0] tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_center  <= irpd_pkg::START_CENTER_RST;
      repeat_center <= irpd_pkg::REPEAT_CENTER_RST;
      zero_center   <= irpd_pkg::ZERO_CENTER_RST;
      one_center    <= irpd_pkg::ONE_CENTER_RST;
      tolerance     <= irpd_pkg::TOLERANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        irpd_pkg::REG_START_CENTER:  start_center  <= cfg_data;
        irpd_pkg::REG_REPEAT_CENTER: repeat_center <= cfg_data;
        irpd_pkg::REG_ZERO_CENTER:   zero_center   <= cfg_data;
        irpd_pkg::REG_ONE_CENTER:    one_center    <= cfg_data;
        irpd_pkg::REG_TOLERANCE:     tolerance     <= cfg_data;
        default: ;
      endcase
    end
  end

  // c - t < v < c + t  <=>  v + t > c  and  v < c + t, all in 17 bits
  function automatic logic hit(input logic [irpd_pkg::TICK_W-1:0] v,
                               input logic [irpd_pkg::TICK_W-1:0] c,
                               input logic [irpd_pkg::TICK_W-1:0] t);
    logic [irpd_pkg::TICK_W:0] vt;
    logic [irpd_pkg::TICK_W:0] ct;
    vt = {1'b0, v} + {1'b0, t};
    ct = {1'b0, c} + {1'b0, t};
    return (vt > {1'b0, c}) && ({1'b0, v} < ct);
  endfunction

  always_comb begin
    cls.start_hit  = hit(interval_ticks, start_center, tolerance);
    cls.repeat_hit = hit(interval_ticks, repeat_center, tolerance);
    cls.zero_hit   = hit(interval_ticks, zero_center, tolerance);
    cls.one_hit    = hit(interval_ticks, one_center, tolerance);
  end

endmodule

// ----- sv/irpd_queue.sv -----
// Two-entry queue of classified intervals between front and back.
// Depends on irpd_pkg.
module irpd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  irpd_pkg::cls_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output irpd_pkg::cls_t rd_data
);

  irpd_pkg::cls_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/irpd_exec.sv -----
// Back end of the IR decoder: idle/lead/data state machine, shift register,
// complement check and the result output register. Depends on irpd_pkg.
module irpd_exec (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  irpd_pkg::cls_t                in_cls,
  output logic                          in_take,
  output logic                          empty,
  input  logic                          pop,
  output logic                          new_frame,
  output logic                          repeat_seen,
  output logic [irpd_pkg::BYTE_W-1:0]   address_out,
  output logic [irpd_pkg::BYTE_W-1:0]   command_out
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEAD = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  phase_t                               phase, phase_next;
  logic [irpd_pkg::CNT_W-1:0]           bit_count, bit_count_next;
  logic [irpd_pkg::FRAME_BITS-1:0]      shift_bits, shift_bits_next;
  logic [irpd_pkg::BYTE_W-1:0]          held_address, held_address_next;
  logic [irpd_pkg::BYTE_W-1:0]          held_command, held_command_next;
  logic                                 frame_done, repeat_done;
  logic                                 out_valid;
  logic [irpd_pkg::BIT_IDX_W-1:0]       bit_idx;

  assign empty   = ~out_valid;
  assign in_take = in_valid && (!out_valid || pop);
  assign bit_idx = bit_count[irpd_pkg::BIT_IDX_W-1:0];

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    shift_bits_next   = shift_bits;
    held_address_next = held_address;
    held_command_next = held_command;
    frame_done        = 1'b0;
    repeat_done       = 1'b0;
    case (phase)
      PH_LEAD: begin
        if (in_cls.start_hit) begin
          bit_count_next = '0;
          phase_next     = PH_DATA;
        end else if (in_cls.repeat_hit) begin
          repeat_done = 1'b1;
          phase_next  = PH_IDLE;
        end
      end
      PH_DATA: begin
        if (in_cls.zero_hit || in_cls.one_hit) begin
          shift_bits_next[bit_idx] = !in_cls.zero_hit;
          bit_count_next           = bit_count + 1'b1;
        end else begin
          bit_count_next = '0;
          phase_next     = PH_LEAD;
        end
        // last bit in: check byte complements
        if (bit_count_next == irpd_pkg::CNT_W'(irpd_pkg::FRAME_BITS)) begin
          bit_count_next = '0;
          phase_next     = PH_IDLE;
          if (shift_bits_next[7:0] == ~shift_bits_next[15:8] &&
              shift_bits_next[23:16] == ~shift_bits_next[31:24]) begin
            held_address_next = shift_bits_next[7:0];
            held_command_next = shift_bits_next[23:16];
            frame_done        = 1'b1;
          end
        end
      end
      default: begin
        // first edge is not classified; it only moves the state machine to the lead phase
        phase_next = PH_LEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      shift_bits   <= '0;
      held_address <= '0;
      held_command <= '0;
      out_valid    <= 1'b0;
      new_frame    <= 1'b0;
      repeat_seen  <= 1'b0;
      address_out  <= '0;
      command_out  <= '0;
    end else begin
      if (in_take) begin
        phase        <= phase_next;
        bit_count    <= bit_count_next;
        shift_bits   <= shift_bits_next;
        held_address <= held_address_next;
        held_command <= held_command_next;
        out_valid    <= 1'b1;
        new_frame    <= frame_done;
        repeat_seen  <= repeat_done;
        address_out  <= held_address_next;
        command_out  <= held_command_next;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/ir_remote_pulse_distance_decoder_top.sv -----
// Top level of the pulse-distance (NEC style) IR remote decoder.
// Depends on irpd_pkg, irpd_front, irpd_queue and irpd_exec.
//
// Usage:
//  - Input channel: one word per falling edge, interval_ticks = timer ticks
//    since the previous edge. Word is taken when push is high and full is low.
//  - Result channel: one word per input word (new_frame, repeat_seen and the
//    last accepted address/command bytes). Oldest result is shown while empty
//    is low and is taken when pop is high.
//  - Config: cfg_we writes cfg_data into register cfg_index (0 start center,
//    1 repeat center, 2 zero center, 3 one center, 4 tolerance); other
//    indexes are ignored. Write only while the block is idle.
//  - Front classifies the interval against the windows into a two-entry
//    queue; back runs the frame state machine and fills the result register.
//  - Path: a pushed word is written into a queue slot, then loaded into the
//    result register and shown on the result ports when that register is free.
//  - Throughput: one word per cycle while pop keeps the result register free;
//    pop in the same cycle as a new result is loaded is fine.
//  - Stall: if pop stays low, the result register holds, the queue fills
//    within two more words and full rises; nothing is dropped.
//  - Reset (rst, synchronous): registers go to their default windows, state
//    machine goes idle, held bytes are cleared, queue and result are empty.
module ir_remote_pulse_distance_decoder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [irpd_pkg::TICK_W-1:0]       interval_ticks,
  output logic                              empty,
  input  logic                              pop,
  output logic                              new_frame,
  output logic                              repeat_seen,
  output logic [irpd_pkg::BYTE_W-1:0]       address_out,
  output logic [irpd_pkg::BYTE_W-1:0]       command_out,
  input  logic                              cfg_we,
  input  logic [irpd_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [irpd_pkg::TICK_W-1:0]       cfg_data
);

  irpd_pkg::cls_t front_cls;
  irpd_pkg::cls_t q_cls;
  logic           q_valid;
  logic           q_take;
  logic           wr_en;

  // accept handshake on the input side
  assign wr_en = push && !full;

  irpd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .interval_ticks (interval_ticks),
    .cls            (front_cls)
  );

  irpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_data  (front_cls),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_data  (q_cls)
  );

  irpd_exec u_exec (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_cls      (q_cls),
    .in_take     (q_take),
    .empty       (empty),
    .pop         (pop),
    .new_frame   (new_frame),
    .repeat_seen (repeat_seen),
    .address_out (address_out),
    .command_out (command_out)
  );

endmodule
